[rtl/core/lpe_pkg.sv]
// Package for the lift position estimator: command codes, register indexes,
// reset values, shared types and the constant-divisor helper functions.
// No dependencies.
`default_nettype none

package lpe_pkg;

  // Remote command codes.
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_STOP = 2'd1;
  localparam logic [1:0] OP_UP   = 2'd2;
  localparam logic [1:0] OP_DOWN = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_UP_RATE    = 2'd0;
  localparam logic [1:0] CFG_DOWN_RATE  = 2'd1;
  localparam logic [1:0] CFG_START_WAIT = 2'd2;
  localparam logic [1:0] CFG_TOP_HEIGHT = 2'd3;

  localparam int CFG_W    = 20;
  localparam int RATE_W   = 10;
  localparam int WAIT_W   = 16;
  localparam int HEIGHT_W = 20;
  localparam int COARSE_W = 10;
  localparam int TIME_W   = 32;
  localparam int TQ_W     = 29;  // bits of a 32-bit time divided by ten
  localparam int INC_W    = 40;

  localparam logic [RATE_W-1:0]   UP_RATE_RST    = 10'd42;
  localparam logic [RATE_W-1:0]   DOWN_RATE_RST  = 10'd50;
  localparam logic [WAIT_W-1:0]   START_WAIT_RST = 16'd1000;
  localparam logic [HEIGHT_W-1:0] TOP_HEIGHT_RST = 20'd100000;

  // 2^32 / 10 = WRAP_Q remainder 6; used when the elapsed time wraps.
  localparam logic [TIME_W-1:0] WRAP_Q = 32'd429496729;
  localparam logic [9:0]        COARSE_MAX = 10'd1023;

  // A time value split into tenths and remainder.
  typedef struct packed {
    logic [TQ_W-1:0] q;
    logic [3:0]      r;
  } tdiv_t;

  // A time mark with its tenths and remainder kept alongside.
  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [TQ_W-1:0]   q;
    logic [3:0]        r;
  } mark_t;

  // A rate split into tens and units.
  typedef struct packed {
    logic [6:0] q;
    logic [3:0] r;
  } rate_t;

  // Divides a 32-bit time by ten. 65536 = 10 * 6553 + 6, so the upper half
  // contributes directly and the small residue goes through a reciprocal.
  function automatic tdiv_t div10_time(input logic [TIME_W-1:0] v);
    logic [18:0] s;
    logic [37:0] p;
    logic [15:0] qs;
    tdiv_t       res;
    s      = 19'(v[31:16]) * 19'd6 + 19'(v[15:0]);
    p      = 38'(s) * 38'd419431;
    qs     = p[37:22];
    res.q  = 29'(v[31:16]) * 29'd6553 + 29'(qs);
    res.r  = 4'(s - 19'(qs) * 19'd10);
    return res;
  endfunction

  function automatic rate_t split_rate(input logic [RATE_W-1:0] v);
    logic [19:0] p;
    rate_t       res;
    p     = 20'(v) * 20'd820;
    res.q = p[19:13];
    res.r = 4'(v - 10'(res.q) * 10'd10);
    return res;
  endfunction

  // floor(a * b / 10) for single decimal digits.
  function automatic logic [3:0] digit_tenth(input logic [3:0] a, input logic [3:0] b);
    logic [6:0]  p;
    logic [14:0] t;
    p = 7'(a) * 7'(b);
    t = 15'(p) * 15'd205;
    return t[14:11];
  endfunction

  // Height in thousands, saturated to the field.
  function automatic logic [COARSE_W-1:0] coarse_of(input logic [HEIGHT_W-1:0] h);
    logic [40:0] p;
    logic [10:0] q;
    p = 41'(h) * 41'd1073742;
    q = p[40:30];
    return (q > 11'(COARSE_MAX)) ? COARSE_MAX : q[9:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/lift_position_estimator.sv]
// Each transaction passes the input register, the tenths split, the state update and
// the output register. Throughput: one transaction per cycle unless out_stall holds
// it back; a control pass updates in a single stage, so items follow without gaps.
// Reset (synchronous, active low) clears both direction flags, both time marks and
// the height, and loads the registers with up 42, down 50, wait 1000, top 100000.
// Depends on lpe_pkg.
`default_nettype none

module lift_position_estimator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_idx,
  input  wire logic [lpe_pkg::CFG_W-1:0]     cfg_wdata,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lpe_pkg::TIME_W-1:0]    in_now_ms,
  input  wire logic                          in_motor_running,
  input  wire logic                          in_up_press,
  input  wire logic                          in_down_press,
  input  wire logic [1:0]                    in_op,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [lpe_pkg::HEIGHT_W-1:0]       out_height,
  output logic [lpe_pkg::COARSE_W-1:0]       out_height_coarse,
  output logic                               out_going_up,
  output logic                               out_going_down,
  output logic                               out_moving
);
  import lpe_pkg::*;

  // Configuration.
  rate_t               up_rate_r;
  rate_t               down_rate_r;
  logic [WAIT_W-1:0]   start_wait_r;
  logic [HEIGHT_W-1:0] top_height_r;

  // Pipeline control.
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_en, s2_en, s3_en, out_en, upd;

  // Stage 1: input register.
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_run_r, s1_upb_r, s1_downb_r;
  logic [1:0]        s1_op_r;

  // Stage 2: item with its time split into tenths.
  logic [TIME_W-1:0] s2_now_r;
  tdiv_t             s2_div_r;
  logic              s2_run_r, s2_upb_r, s2_downb_r;
  logic [1:0]        s2_op_r;

  // Estimator state; stage 3 reads it directly, as it only moves on with stage 3.
  logic                up_flag_r, down_flag_r;
  mark_t               up_mark_r, down_mark_r;
  logic [HEIGHT_W-1:0] height_r;

  logic                up_nxt, down_nxt;
  mark_t               up_mark_nxt, down_mark_nxt;
  logic [HEIGHT_W-1:0] height_nxt;

  // After the button presses.
  logic  up_p, down_p;
  mark_t up_mark_p, down_mark_p, fresh;

  // Elapsed time and increment.
  mark_t               el_mark;
  rate_t               el_rate;
  logic [TIME_W-1:0]   el;
  logic                el_wrap;
  logic signed [5:0]   el_rdiff;
  logic [TIME_W-1:0]   el_qbase, el_q32;
  logic [3:0]          el_rem;
  logic [INC_W-1:0]    inc;
  logic [INC_W:0]      up_sum;

  // Output register.
  logic [HEIGHT_W-1:0] out_height_r;
  logic [COARSE_W-1:0] out_coarse_r;
  logic                out_up_r, out_down_r;

  assign out_en   = !out_valid_r || !out_stall;
  assign s3_en    = !s3_valid_r || out_en;
  assign s2_en    = !s2_valid_r || s3_en;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_stall = !s1_en;
  assign upd      = s2_valid_r && s3_en;

  assign fresh = '{t: s2_now_r, q: s2_div_r.q, r: s2_div_r.r};

  // Button presses toggle their direction and clear the other one.
  always_comb begin
    up_p        = up_flag_r;
    down_p      = down_flag_r;
    up_mark_p   = up_mark_r;
    down_mark_p = down_mark_r;
    if (s2_upb_r) begin
      down_p = 1'b0;
      up_p   = !up_flag_r;
      if (up_p) begin
        up_mark_p = fresh;
      end
    end
    if (s2_downb_r) begin
      up_p   = 1'b0;
      down_p = !down_p;
      if (down_p) begin
        down_mark_p = fresh;
      end
    end
  end

  // Elapsed time since the active mark. The increment is split as
  // el * (10 rq + rr) / 10 = el * rq + qe * rr + floor(re * rr / 10), with
  // qe and re worked out from the tenths kept with the time and the mark.
  always_comb begin
    el_mark  = up_p ? up_mark_p : down_mark_p;
    el_rate  = up_p ? up_rate_r : down_rate_r;
    el       = s2_now_r - el_mark.t;
    el_wrap  = s2_now_r < el_mark.t;
    el_rdiff = $signed({2'b00, s2_div_r.r}) - $signed({2'b00, el_mark.r})
             + (el_wrap ? 6'sd6 : 6'sd0);
    el_qbase = 32'(s2_div_r.q) - 32'(el_mark.q) + (el_wrap ? WRAP_Q : 32'd0);
    if (el_rdiff < 6'sd0) begin
      el_q32 = el_qbase - 32'd1;
      el_rem = 4'(el_rdiff + 6'sd10);
    end else if (el_rdiff >= 6'sd10) begin
      el_q32 = el_qbase + 32'd1;
      el_rem = 4'(el_rdiff - 6'sd10);
    end else begin
      el_q32 = el_qbase;
      el_rem = 4'(el_rdiff);
    end
    inc    = 40'(el) * 40'(el_rate.q)
           + 40'(el_q32[TQ_W-1:0]) * 40'(el_rate.r)
           + 40'(digit_tenth(el_rem, el_rate.r));
    up_sum = 41'(height_r) + 41'(inc);
  end

  // Height update, then the remote command.
  always_comb begin
    up_nxt        = up_p;
    down_nxt      = down_p;
    up_mark_nxt   = up_mark_p;
    down_mark_nxt = down_mark_p;
    height_nxt    = height_r;
    if (up_p) begin
      if (!s2_run_r) begin
        if (el > 32'(start_wait_r)) begin
          height_nxt = top_height_r;
          up_nxt     = 1'b0;
          down_nxt   = 1'b0;
        end
      end else begin
        height_nxt  = (up_sum > 41'(top_height_r)) ? top_height_r : up_sum[HEIGHT_W-1:0];
        up_mark_nxt = fresh;
      end
    end else if (down_p) begin
      if (!s2_run_r) begin
        if (el > 32'(start_wait_r)) begin
          height_nxt = '0;
          up_nxt     = 1'b0;
          down_nxt   = 1'b0;
        end
      end else begin
        height_nxt    = (inc >= 40'(height_r)) ? '0 : height_r - inc[HEIGHT_W-1:0];
        down_mark_nxt = fresh;
      end
    end
    case (s2_op_r)
      OP_NONE: begin
      end
      OP_STOP: begin
        up_nxt   = 1'b0;
        down_nxt = 1'b0;
      end
      OP_UP: begin
        down_nxt = 1'b0;
        if (!up_nxt) begin
          up_nxt      = 1'b1;
          up_mark_nxt = fresh;
        end
      end
      OP_DOWN: begin
        up_nxt = 1'b0;
        if (!down_nxt) begin
          down_nxt      = 1'b1;
          down_mark_nxt = fresh;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration registers; rates are kept split into tens and units.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_rate_r    <= split_rate(UP_RATE_RST);
      down_rate_r  <= split_rate(DOWN_RATE_RST);
      start_wait_r <= START_WAIT_RST;
      top_height_r <= TOP_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_UP_RATE:    up_rate_r    <= split_rate(cfg_wdata[RATE_W-1:0]);
        CFG_DOWN_RATE:  down_rate_r  <= split_rate(cfg_wdata[RATE_W-1:0]);
        CFG_START_WAIT: start_wait_r <= cfg_wdata[WAIT_W-1:0];
        CFG_TOP_HEIGHT: top_height_r <= cfg_wdata[HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Valid bits and estimator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      up_flag_r   <= 1'b0;
      down_flag_r <= 1'b0;
      up_mark_r   <= '0;
      down_mark_r <= '0;
      height_r    <= '0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= in_valid;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_en) begin
        s3_valid_r <= s2_valid_r;
      end
      if (out_en) begin
        out_valid_r <= s3_valid_r;
      end
      if (upd) begin
        up_flag_r   <= up_nxt;
        down_flag_r <= down_nxt;
        up_mark_r   <= up_mark_nxt;
        down_mark_r <= down_mark_nxt;
        height_r    <= height_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_now_r   <= in_now_ms;
      s1_run_r   <= in_motor_running;
      s1_upb_r   <= in_up_press;
      s1_downb_r <= in_down_press;
      s1_op_r    <= in_op;
    end
    if (s2_en && s1_valid_r) begin
      s2_now_r   <= s1_now_r;
      s2_div_r   <= div10_time(s1_now_r);
      s2_run_r   <= s1_run_r;
      s2_upb_r   <= s1_upb_r;
      s2_downb_r <= s1_downb_r;
      s2_op_r    <= s1_op_r;
    end
    if (out_en && s3_valid_r) begin
      out_height_r <= height_r;
      out_coarse_r <= coarse_of(height_r);
      out_up_r     <= up_flag_r;
      out_down_r   <= down_flag_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_height        = out_height_r;
  assign out_height_coarse = out_coarse_r;
  assign out_going_up      = out_up_r;
  assign out_going_down    = out_down_r;
  assign out_moving        = out_up_r || out_down_r;

  a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(up_flag_r && down_flag_r))
    else $error("both direction flags set");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> ($stable(height_r) && $stable(up_flag_r) && $stable(down_flag_r)))
    else $error("estimator state changed without a transaction");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && s2_op_r == OP_STOP) |=> (!up_flag_r && !down_flag_r))
    else $error("stop command left a direction active");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && s3_valid_r && s2_valid_r && s1_valid_r) |-> in_stall)
    else $error("input accepted into a full pipeline");

endmodule

`default_nettype wire
